[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. They compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SCA_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

`define SCA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define SCA_ASSERT_IMP(label, clk, rst_n, cond, prop)

`define SCA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[hw/rtl/sca_pkg.sv]
package sca_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_NO_OWNER = 2'd2;
    localparam logic [1:0] STATUS_NO_RUN   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OWNER_SCAN,
        ST_RUN_SCAN,
        ST_SLOT_COMMIT,
        ST_OWNER_COMMIT,
        ST_READ_SCAN,
        ST_FINISH
    } state_t;

    // Control shared by every cell of a ring.
    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctrl_t;

endpackage

[hw/rtl/sca_cell.sv]
module sca_cell #(
    parameter int WIDTH = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sca_pkg::ring_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    shift_in,
    output logic [WIDTH-1:0]    data
);
    import sca_pkg::*;

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        if (ctrl.clear)
        begin
            data_next = '0;
        end
        else if (ctrl.shift)
        begin
            data_next = shift_in;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

[hw/rtl/sca_ring.sv]
module sca_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sca_pkg::ring_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    tail_data,
    output logic [WIDTH-1:0]    head_data
);
    import sca_pkg::*;

    // Data moves toward cell 0; the head's value, possibly modified, re-enters
    // at the last cell, so DEPTH shifts bring every entry back to its place.
    logic [WIDTH-1:0] cell_data [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [WIDTH-1:0] cell_in;

        if (k == DEPTH - 1)
        begin : g_last
            assign cell_in = tail_data;
        end
        else
        begin : g_mid
            assign cell_in = cell_data[k+1];
        end

        sca_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .shift_in(cell_in),
            .data    (cell_data[k])
        );
    end

    assign head_data = cell_data[0];

endmodule

[hw/rtl/contiguous_slot_allocator.sv]
// First-fit allocator of contiguous slot runs, each run tagged with an owner id.
// Requests arrive on req_valid/req_ready with command, run_length and slot_index;
// each request yields exactly one result on rsp_valid/rsp_ready.
// The slot map and the owner map are rings of cells that rotate past one head
// cell; each pass over a map rotates it by one entry per cycle.
// Allocate: owner scan (OWNER_COUNT), run scan (SLOT_COUNT), slot marking pass
// (SLOT_COUNT), owner marking pass (OWNER_COUNT), then the result is loaded into
// the output register.
// A failed allocate returns after the pass that failed; a bad length returns
// without any pass. Read makes one pass over the slot map; map reset and the
// unused command make none.
// One request is in work at a time; req_ready is high while no request is in work,
// even while the previous result still waits in the output register.
// If the receiver stalls, a finished request holds until the output register
// frees, and no new request is taken meanwhile.
// Reset (rst_n) clears both maps, both high-water marks and rsp_valid
// at once; no clearing pass is needed.
`include "assert_macros.svh"

module contiguous_slot_allocator #(
    parameter int SLOT_COUNT  = 256,
    parameter int OWNER_COUNT = 64,
    localparam int SIDX_W = $clog2(SLOT_COUNT),
    localparam int LEN_W  = $clog2(SLOT_COUNT + 1),
    localparam int OID_W  = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1,
    localparam int OM_W   = $clog2(OWNER_COUNT + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        command,
    input  logic [LEN_W-1:0]  run_length,
    input  logic [SIDX_W-1:0] slot_index,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [1:0]        status,
    output logic [OID_W-1:0]  owner_id,
    output logic [SIDX_W-1:0] base_slot,
    output logic [OID_W-1:0]  slot_owner,
    output logic [LEN_W-1:0]  slot_high_mark,
    output logic [OM_W-1:0]   owner_high_mark
);
    import sca_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]        cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SIDX_W-1:0] idx_reg;
    logic [SIDX_W-1:0] slot_cnt_reg;
    logic [OID_W-1:0]  owner_cnt_reg;
    logic              owner_found_reg;
    logic [OID_W-1:0]  owner_sel_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [SIDX_W-1:0] start_reg;
    logic              run_found_reg;
    logic [SIDX_W-1:0] base_reg;
    logic [OID_W-1:0]  rd_reg;
    logic [1:0]        result_status_reg;
    logic [LEN_W-1:0]  slot_mark_reg;
    logic [OM_W-1:0]   owner_mark_reg;

    logic              rsp_valid_reg;
    logic [1:0]        rsp_status_reg;
    logic [OID_W-1:0]  rsp_owner_reg;
    logic [SIDX_W-1:0] rsp_base_reg;
    logic [OID_W-1:0]  rsp_rd_reg;
    logic [LEN_W-1:0]  rsp_slot_mark_reg;
    logic [OM_W-1:0]   rsp_owner_mark_reg;

    ring_ctrl_t        slot_ctrl;
    ring_ctrl_t        owner_ctrl;
    logic              accept;
    logic              load_rsp;

    logic [OID_W:0]    slot_head, slot_tail;
    logic              owner_head, owner_tail;

    logic              bad_len;
    logic              slot_last, owner_last;
    logic              owner_free_now;
    logic [LEN_W-1:0]  run_inc;
    logic              run_hit;
    logic [SIDX_W-1:0] run_start;
    logic [LEN_W-1:0]  run_end;
    logic [LEN_W-1:0]  slot_pos;
    logic              in_run;
    logic [OM_W-1:0]   owner_end;
    logic              granted;

    assign bad_len    = (run_length == '0) || (run_length >= LEN_W'(SLOT_COUNT));
    assign slot_last  = (slot_cnt_reg == SIDX_W'(SLOT_COUNT - 1));
    assign owner_last = (owner_cnt_reg == OID_W'(OWNER_COUNT - 1));

    assign owner_free_now = !owner_head && !owner_found_reg;

    // First-fit run tracking on the slot that sits at the head this cycle.
    assign run_inc   = run_reg + LEN_W'(1);
    assign run_start = (run_reg == '0) ? slot_cnt_reg : start_reg;
    assign run_hit   = !slot_head[OID_W] && !run_found_reg && (run_inc >= len_reg);

    assign run_end   = LEN_W'(base_reg) + len_reg;
    assign slot_pos  = LEN_W'(slot_cnt_reg);
    assign in_run    = (slot_cnt_reg >= base_reg) && (slot_pos < run_end);
    assign owner_end = OM_W'(owner_sel_reg) + OM_W'(1);
    assign granted   = (cmd_reg == CMD_ALLOC) && (result_status_reg == STATUS_OK);

    assign slot_tail  = (state_reg == ST_SLOT_COMMIT && in_run) ?
                        {1'b1, owner_sel_reg} : slot_head;
    assign owner_tail = (state_reg == ST_OWNER_COMMIT && owner_cnt_reg == owner_sel_reg) ?
                        1'b1 : owner_head;

    sca_ring #(
        .DEPTH(SLOT_COUNT),
        .WIDTH(OID_W + 1)
    ) u_slot_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (slot_ctrl),
        .tail_data(slot_tail),
        .head_data(slot_head)
    );

    sca_ring #(
        .DEPTH(OWNER_COUNT),
        .WIDTH(1)
    ) u_owner_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (owner_ctrl),
        .tail_data(owner_tail),
        .head_data(owner_head)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (command)
                        CMD_ALLOC: state_next = bad_len ? ST_FINISH : ST_OWNER_SCAN;
                        CMD_READ:  state_next = ST_READ_SCAN;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_OWNER_SCAN:
            begin
                if (owner_last)
                begin
                    state_next = (owner_found_reg || !owner_head) ? ST_RUN_SCAN : ST_FINISH;
                end
            end
            ST_RUN_SCAN:
            begin
                if (slot_last)
                begin
                    state_next = (run_found_reg || run_hit) ? ST_SLOT_COMMIT : ST_FINISH;
                end
            end
            ST_SLOT_COMMIT:
            begin
                if (slot_last)
                begin
                    state_next = ST_OWNER_COMMIT;
                end
            end
            ST_OWNER_COMMIT:
            begin
                if (owner_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_SCAN:
            begin
                if (slot_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controls decoded from the state, and map clearing from an accepted reset command.
    always_comb
    begin
        req_ready        = 1'b0;
        load_rsp         = 1'b0;
        slot_ctrl.shift  = 1'b0;
        owner_ctrl.shift = 1'b0;
        case (state_reg)
            ST_IDLE:         req_ready        = 1'b1;
            ST_OWNER_SCAN:   owner_ctrl.shift = 1'b1;
            ST_RUN_SCAN:     slot_ctrl.shift  = 1'b1;
            ST_SLOT_COMMIT:  slot_ctrl.shift  = 1'b1;
            ST_OWNER_COMMIT: owner_ctrl.shift = 1'b1;
            ST_READ_SCAN:    slot_ctrl.shift  = 1'b1;
            ST_FINISH:       load_rsp         = !rsp_valid_reg || rsp_ready;
            default:         req_ready        = 1'b0;
        endcase
        accept           = req_ready && req_valid;
        slot_ctrl.clear  = accept && (command == CMD_RESET);
        owner_ctrl.clear = accept && (command == CMD_RESET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_cnt_reg   <= '0;
            owner_cnt_reg  <= '0;
            slot_mark_reg  <= '0;
            owner_mark_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (slot_ctrl.shift)
            begin
                slot_cnt_reg <= slot_last ? '0 : slot_cnt_reg + SIDX_W'(1);
            end
            if (owner_ctrl.shift)
            begin
                owner_cnt_reg <= owner_last ? '0 : owner_cnt_reg + OID_W'(1);
            end

            if (accept && command == CMD_RESET)
            begin
                slot_mark_reg  <= '0;
                owner_mark_reg <= '0;
            end
            else if (state_reg == ST_OWNER_COMMIT && owner_last)
            begin
                if (run_end > slot_mark_reg)
                begin
                    slot_mark_reg <= run_end;
                end
                if (owner_end > owner_mark_reg)
                begin
                    owner_mark_reg <= owner_end;
                end
            end

            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Per-request working registers and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg           <= command;
            len_reg           <= run_length;
            idx_reg           <= slot_index;
            owner_found_reg   <= 1'b0;
            owner_sel_reg     <= '0;
            run_reg           <= '0;
            start_reg         <= '0;
            run_found_reg     <= 1'b0;
            base_reg          <= '0;
            rd_reg            <= '0;
            result_status_reg <= (command == CMD_ALLOC && bad_len) ? STATUS_BAD_LEN : STATUS_OK;
        end

        if (state_reg == ST_OWNER_SCAN)
        begin
            if (owner_free_now)
            begin
                owner_found_reg <= 1'b1;
                owner_sel_reg   <= owner_cnt_reg;
            end
            else if (owner_last && !owner_found_reg)
            begin
                result_status_reg <= STATUS_NO_OWNER;
            end
        end

        if (state_reg == ST_RUN_SCAN && !run_found_reg)
        begin
            if (slot_head[OID_W])
            begin
                run_reg <= '0;
            end
            else
            begin
                run_reg   <= run_inc;
                start_reg <= run_start;
            end
            if (run_hit)
            begin
                run_found_reg <= 1'b1;
                base_reg      <= run_start;
            end
            else if (slot_last)
            begin
                result_status_reg <= STATUS_NO_RUN;
            end
        end

        if (state_reg == ST_READ_SCAN && slot_cnt_reg == idx_reg)
        begin
            rd_reg <= slot_head[OID_W-1:0];
        end

        if (load_rsp)
        begin
            rsp_status_reg     <= result_status_reg;
            rsp_owner_reg      <= granted ? owner_sel_reg : '0;
            rsp_base_reg       <= granted ? base_reg : '0;
            rsp_rd_reg         <= (cmd_reg == CMD_READ) ? rd_reg : '0;
            rsp_slot_mark_reg  <= slot_mark_reg;
            rsp_owner_mark_reg <= owner_mark_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = rsp_status_reg;
    assign owner_id        = rsp_owner_reg;
    assign base_slot       = rsp_base_reg;
    assign slot_owner      = rsp_rd_reg;
    assign slot_high_mark  = rsp_slot_mark_reg;
    assign owner_high_mark = rsp_owner_mark_reg;

    `SCA_ASSERT_IMP(a_run_scan_has_owner, clk, rst_n, state_reg == ST_RUN_SCAN, owner_found_reg)
    `SCA_ASSERT_IMP(a_commit_has_run, clk, rst_n, state_reg == ST_SLOT_COMMIT, run_found_reg)
    `SCA_ASSERT_IMP(a_run_fits, clk, rst_n, state_reg == ST_SLOT_COMMIT, run_end <= LEN_W'(SLOT_COUNT))
    `SCA_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, accept, state_reg != ST_IDLE)

endmodule
